FILE: hdl/hrfs_pkg.sv
// ----------------------------------------------------------------------------
// HTTP request field splitter package
// Shared widths, field kind codes and the header key text.
// ----------------------------------------------------------------------------
package hrfs_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned PHASE_W = 4;
	localparam int unsigned MATCH_W = 3;

	typedef logic [BYTE_W-1:0]  byte_t;
	typedef logic [KIND_W-1:0]  kind_t;
	typedef logic [PHASE_W-1:0] phase_t;
	typedef logic [MATCH_W-1:0] match_t;

	// Field kind codes carried on the result channel.
	localparam kind_t KIND_URL    = 2'd0;
	localparam kind_t KIND_COOKIE = 2'd1;
	localparam kind_t KIND_BODY   = 2'd2;

	// Number of characters in the cookie header key.
	localparam match_t KEY_LEN = 3'd7;

	// Space, CR and LF; key_char gives the text "Cookie:", with a terminating zero past its end.
	localparam byte_t CHAR_SP = 8'h20;
	localparam byte_t CHAR_CR = 8'h0D;
	localparam byte_t CHAR_LF = 8'h0A;

	function automatic byte_t key_char(input match_t idx);
		byte_t ch;
		begin
			case (idx)
				3'd0:    ch = 8'h43; // C
				3'd1:    ch = 8'h6F; // o
				3'd2:    ch = 8'h6F; // o
				3'd3:    ch = 8'h6B; // k
				3'd4:    ch = 8'h69; // i
				3'd5:    ch = 8'h65; // e
				3'd6:    ch = 8'h3A; // :
				default: ch = 8'h00;
			endcase
			return ch;
		end
	endfunction

endpackage

FILE: hdl/hrfs_in_if.sv
// ----------------------------------------------------------------------------
// HTTP request field splitter input channel
// Carries one raw request byte per word with its last-byte mark.
// ----------------------------------------------------------------------------
interface hrfs_in_if
	import hrfs_pkg::*;
;
	logic  valid;
	logic  ready;
	byte_t data_byte;
	logic  last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: hdl/hrfs_out_if.sv
// ----------------------------------------------------------------------------
// HTTP request field splitter result channel
// Carries one tagged field byte, cookie marker or end mark per word.
// ----------------------------------------------------------------------------
interface hrfs_out_if
	import hrfs_pkg::*;
;
	logic  valid;
	logic  ready;
	logic  byte_valid;
	byte_t out_byte;
	kind_t field_kind;
	logic  value_start;
	logic  request_end;

	modport source (output valid, output byte_valid, output out_byte, output field_kind,
		output value_start, output request_end, input ready);
	modport sink   (input valid, input byte_valid, input out_byte, input field_kind,
		input value_start, input request_end, output ready);
endinterface

FILE: hdl/http_request_field_splitter_unit.sv
// ----------------------------------------------------------------------------
// HTTP request field splitter
// Tags request bytes as URL, cookie value or body on a streaming channel.
// ----------------------------------------------------------------------------
// The block takes one request byte per clock cycle and sustains that rate
// indefinitely while the result side keeps up. Each word passes through an
// input register and the parser state update, and its result word (if any)
// appears from the result register, which holds it until taken. Bytes that
// belong to no field give no result word, except that the last byte of a
// request always gives one with request_end set, after which the parser
// returns to its reset state. An empty cookie value is signalled by a word
// with byte_valid low, field_kind cookie and value_start high.
module http_request_field_splitter_unit
	import hrfs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	hrfs_in_if.sink     req,
	hrfs_out_if.source  fld
);

	// Parser phase codes.
	localparam phase_t PH_METHOD   = 4'd0;
	localparam phase_t PH_URL      = 4'd1;
	localparam phase_t PH_REQLINE  = 4'd2;
	localparam phase_t PH_LINE     = 4'd3;
	localparam phase_t PH_MATCH    = 4'd4;
	localparam phase_t PH_SKIPLINE = 4'd5;
	localparam phase_t PH_SKIPONE  = 4'd6;
	localparam phase_t PH_VALUE    = 4'd7;
	localparam phase_t PH_ENDCR    = 4'd8;
	localparam phase_t PH_BODY     = 4'd9;

	logic   valid_s1;
	byte_t  data_s1;
	logic   last_s1;

	phase_t phase_q;
	match_t match_q;
	logic   fresh_q;

	logic   out_valid_q;
	logic   byte_valid_q;
	byte_t  out_byte_q;
	kind_t  kind_q;
	logic   start_q;
	logic   end_q;

	logic   advance;
	phase_t phase_d;
	match_t match_d;
	logic   fresh_d;
	logic   emit;
	logic   marker;
	kind_t  kind;
	match_t match_inc;
	logic   has_result;

	// The input register moves on whenever the result register is free or draining.
	assign advance   = valid_s1 && (!out_valid_q || fld.ready);
	assign req.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			data_s1 <= req.data_byte;
			last_s1 <= req.last_byte;
		end
	end

	assign match_inc = match_q + 3'd1;

	// Parser step for the word held in the input register.
	always_comb begin
		phase_d = phase_q;
		match_d = match_q;
		fresh_d = fresh_q;
		emit    = 1'b0;
		marker  = 1'b0;
		kind    = KIND_URL;
		unique case (phase_q)
			PH_URL: begin
				if (data_s1 == CHAR_SP) begin
					phase_d = PH_REQLINE;
				end else begin
					emit = 1'b1;
					kind = KIND_URL;
				end
			end
			PH_REQLINE: begin
				if (data_s1 == CHAR_LF) begin
					phase_d = PH_LINE;
				end
			end
			PH_LINE: begin
				if (data_s1 == CHAR_LF) begin
					phase_d = PH_BODY;
					fresh_d = 1'b1;
				end else if (data_s1 == CHAR_CR) begin
					phase_d = PH_ENDCR;
				end else if (data_s1 == key_char(3'd0)) begin
					phase_d = PH_MATCH;
					match_d = 3'd1;
				end else begin
					phase_d = PH_SKIPLINE;
				end
			end
			PH_MATCH: begin
				if (data_s1 == key_char(match_q)) begin
					if (match_inc == KEY_LEN) begin
						phase_d = PH_SKIPONE;
						match_d = 3'd0;
					end else begin
						match_d = match_inc;
					end
				end else begin
					match_d = 3'd0;
					phase_d = (data_s1 == CHAR_LF) ? PH_LINE : PH_SKIPLINE;
				end
			end
			PH_SKIPLINE: begin
				if (data_s1 == CHAR_LF) begin
					phase_d = PH_LINE;
				end
			end
			PH_SKIPONE: begin
				phase_d = PH_VALUE;
				fresh_d = 1'b1;
			end
			PH_VALUE: begin
				if (data_s1 == CHAR_CR || data_s1 == CHAR_LF) begin
					marker  = fresh_q;
					fresh_d = 1'b0;
					phase_d = (data_s1 == CHAR_LF) ? PH_LINE : PH_SKIPLINE;
				end else begin
					emit = 1'b1;
					kind = KIND_COOKIE;
				end
			end
			PH_ENDCR: begin
				if (data_s1 == CHAR_LF) begin
					phase_d = PH_BODY;
					fresh_d = 1'b1;
				end
			end
			PH_BODY: begin
				emit = 1'b1;
				kind = KIND_BODY;
			end
			default: begin
				if (data_s1 == CHAR_SP) begin
					phase_d = PH_URL;
					fresh_d = 1'b1;
				end else begin
					phase_d = PH_METHOD;
				end
			end
		endcase
	end

	assign has_result = emit || marker || last_s1;

	// Parser state; the last byte of a request returns it to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_METHOD;
			match_q <= 3'd0;
			fresh_q <= 1'b1;
		end else if (advance) begin
			if (last_s1) begin
				phase_q <= PH_METHOD;
				match_q <= 3'd0;
				fresh_q <= 1'b1;
			end else begin
				phase_q <= phase_d;
				match_q <= match_d;
				fresh_q <= emit ? 1'b0 : fresh_d;
			end
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= has_result;
		end else if (fld.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			byte_valid_q <= emit;
			out_byte_q   <= emit ? data_s1 : '0;
			kind_q       <= emit ? kind : (marker ? KIND_COOKIE : KIND_URL);
			start_q      <= (emit && fresh_d) || marker;
			end_q        <= last_s1;
		end
	end

	assign fld.valid       = out_valid_q;
	assign fld.byte_valid  = byte_valid_q;
	assign fld.out_byte    = out_byte_q;
	assign fld.field_kind  = kind_q;
	assign fld.value_start = start_q;
	assign fld.request_end = end_q;

endmodule
